// ===== hdl/sgi_pkg.sv =====
// Package: shared types and widths for the segment intersection unit.
`timescale 1ns / 1ps
package sgi_pkg;
  localparam int CW = 16;            // coordinate width
  localparam int DW = CW + 1;        // coordinate difference width
  localparam int PW = 2 * DW;        // product of two differences
  localparam int XW = PW + 1;        // cross product width
  localparam int NW = XW + DW;       // numerator times difference
  localparam int QB = DW;            // quotient bits
  localparam int RW = XW + QB;       // divider remainder width

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 parallel;
  } out_t;

  // Divide request: magnitudes plus sideband
  typedef struct packed {
    logic                 hit;
    logic                 parallel;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic [RW-1:0]        nx;
    logic [RW-1:0]        ny;
    logic [XW-1:0]        d;
  } div_req_t;

  // Divide result: quotient magnitudes plus sideband
  typedef struct packed {
    logic                 hit;
    logic                 parallel;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic [QB-1:0]        qx;
    logic [QB-1:0]        qy;
  } div_res_t;
endpackage

// ===== hdl/segment_intersection_unit.sv =====
// Top level: segment pair intersection pipeline with output register.
`timescale 1ns / 1ps
// Tests two segments A-B and C-D given as signed 16-bit fixed-point points and returns
// one beat per pair: hit, the intersection point (zero without a hit) and a flag for
// parallel segments. A new pair is taken every cycle unless the output stalls. A pair reaches
// the output register through 23 register stages: five front stages (differences,
// products, cross products, range test, magnitudes), 17 divider stages that each settle
// one quotient bit, and the final sign/offset/saturation stage. While the output beat is
// not taken the whole pipeline holds.
module segment_intersection_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sgi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sgi_pkg::out_t out_data
);
  import sgi_pkg::*;

  logic     en;
  logic     fv, dvld;
  div_req_t req;
  div_res_t res;

  // pipeline advances when the output register is free or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sgi_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(fv), .out_req(req)
  );

  sgi_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fv), .in_req(req),
    .out_valid(dvld), .out_res(res)
  );

  // sign, offset from A, saturate
  localparam logic signed [CW+1:0] HI = (CW+2)'((1 << (CW-1)) - 1);
  localparam logic signed [CW+1:0] LO = -HI - 1;
  logic signed [QB:0]   sqx, sqy;
  logic signed [CW+1:0] sx, sy;
  logic signed [CW-1:0] px_next, py_next;
  assign sqx = res.neg_x ? -$signed({1'b0, res.qx}) : $signed({1'b0, res.qx});
  assign sqy = res.neg_y ? -$signed({1'b0, res.qy}) : $signed({1'b0, res.qy});
  assign sx  = (CW+2)'(res.ax) + (CW+2)'(sqx);
  assign sy  = (CW+2)'(res.ay) + (CW+2)'(sqy);
  always_comb begin
    priority if (sx > HI) px_next = CW'(HI);
    else if (sx < LO)     px_next = CW'(LO);
    else                  px_next = CW'(sx);
    priority if (sy > HI) py_next = CW'(HI);
    else if (sy < LO)     py_next = CW'(LO);
    else                  py_next = CW'(sy);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvld;
    if (en) begin
      out_data.hit      <= res.hit;
      out_data.parallel <= res.parallel;
      out_data.px       <= res.hit ? px_next : '0;
      out_data.py       <= res.hit ? py_next : '0;
    end
  end
endmodule

// ===== hdl/sgi_front.sv =====
// Front end: differences, cross products, hit test and numerator products.
`timescale 1ns / 1ps
module sgi_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  sgi_pkg::in_t     in_data,
  output logic             out_valid,
  output sgi_pkg::div_req_t out_req
);
  import sgi_pkg::*;

  // stage 1: differences
  logic v1;
  logic signed [DW-1:0] abx1, aby1, cdx1, cdy1, acx1, acy1;
  logic signed [CW-1:0] ax1, ay1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      abx1 <= DW'(in_data.bx) - DW'(in_data.ax);
      aby1 <= DW'(in_data.by_coord) - DW'(in_data.ay);
      cdx1 <= DW'(in_data.dx) - DW'(in_data.cx);
      cdy1 <= DW'(in_data.dy) - DW'(in_data.cy);
      acx1 <= DW'(in_data.cx) - DW'(in_data.ax);
      acy1 <= DW'(in_data.cy) - DW'(in_data.ay);
      ax1  <= in_data.ax;
      ay1  <= in_data.ay;
    end
  end

  // stage 2: six products
  logic v2;
  logic signed [PW-1:0] p_abx_cdy, p_aby_cdx, p_acx_cdy, p_acy_cdx, p_aby_acx, p_abx_acy;
  logic signed [DW-1:0] abx2, aby2;
  logic signed [CW-1:0] ax2, ay2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      p_abx_cdy <= abx1 * cdy1;
      p_aby_cdx <= aby1 * cdx1;
      p_acx_cdy <= acx1 * cdy1;
      p_acy_cdx <= acy1 * cdx1;
      p_aby_acx <= aby1 * acx1;
      p_abx_acy <= abx1 * acy1;
      abx2 <= abx1;
      aby2 <= aby1;
      ax2  <= ax1;
      ay2  <= ay1;
    end
  end

  // stage 3: cross products
  logic v3;
  logic signed [XW-1:0] den3, sn3, tn3;
  logic signed [DW-1:0] abx3, aby3;
  logic signed [CW-1:0] ax3, ay3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      den3 <= XW'(p_abx_cdy) - XW'(p_aby_cdx);
      sn3  <= XW'(p_acx_cdy) - XW'(p_acy_cdx);
      tn3  <= XW'(p_aby_acx) - XW'(p_abx_acy);
      abx3 <= abx2;
      aby3 <= aby2;
      ax3  <= ax2;
      ay3  <= ay2;
    end
  end

  // stage 4: range test on both numerators, numerator products
  logic s_ok, t_ok;
  always_comb begin
    if (!den3[XW-1]) begin
      s_ok = !sn3[XW-1] && (sn3 <= den3);
      t_ok = !tn3[XW-1] && (tn3 <= den3);
    end else begin
      s_ok = (sn3 <= 0) && (sn3 >= den3);
      t_ok = (tn3 <= 0) && (tn3 >= den3);
    end
  end

  logic v4, par4, hit4, dneg4;
  logic signed [NW-1:0] mx4, my4;
  logic signed [XW-1:0] den4;
  logic signed [CW-1:0] ax4, ay4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      par4  <= (den3 == '0);
      hit4  <= (den3 != '0) && s_ok && t_ok;
      dneg4 <= den3[XW-1];
      mx4   <= NW'(sn3) * NW'(abx3);
      my4   <= NW'(sn3) * NW'(aby3);
      den4  <= den3;
      ax4   <= ax3;
      ay4   <= ay3;
    end
  end

  // stage 5: magnitudes and quotient signs
  logic [NW-1:0] mxa, mya;
  logic [XW-1:0] da;
  assign mxa = mx4[NW-1] ? NW'(-mx4) : NW'(mx4);
  assign mya = my4[NW-1] ? NW'(-my4) : NW'(my4);
  assign da  = den4[XW-1] ? XW'(-den4) : XW'(den4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v4;
    if (en) begin
      out_req.hit      <= hit4;
      out_req.parallel <= par4;
      out_req.neg_x    <= mx4[NW-1] ^ dneg4;
      out_req.neg_y    <= my4[NW-1] ^ dneg4;
      out_req.ax       <= ax4;
      out_req.ay       <= ay4;
      out_req.nx       <= RW'(mxa);
      out_req.ny       <= RW'(mya);
      out_req.d        <= da;
    end
  end
endmodule

// ===== hdl/sgi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y share the divisor.
`timescale 1ns / 1ps
module sgi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  sgi_pkg::div_req_t  in_req,
  output logic               out_valid,
  output sgi_pkg::div_res_t  out_res
);
  import sgi_pkg::*;

  logic          vld [0:QB];
  div_res_t      st  [0:QB];
  logic [RW-1:0] rx  [0:QB];
  logic [RW-1:0] ry  [0:QB];
  logic [XW-1:0] dv  [0:QB];

  // stage 0 is the incoming request
  assign vld[0] = in_valid;
  assign rx[0]  = in_req.nx;
  assign ry[0]  = in_req.ny;
  assign dv[0]  = in_req.d;
  always_comb begin
    st[0].hit      = in_req.hit;
    st[0].parallel = in_req.parallel;
    st[0].neg_x    = in_req.neg_x;
    st[0].neg_y    = in_req.neg_y;
    st[0].ax       = in_req.ax;
    st[0].ay       = in_req.ay;
    st[0].qx       = '0;
    st[0].qy       = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] dsh;
    logic          gx, gy;
    div_res_t      st_next;
    assign dsh = RW'(dv[k]) << SH;
    assign gx  = (rx[k] >= dsh);
    assign gy  = (ry[k] >= dsh);
    always_comb begin
      st_next        = st[k];
      st_next.qx[SH] = gx;
      st_next.qy[SH] = gy;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        st[k+1] <= st_next;
        rx[k+1] <= gx ? rx[k] - dsh : rx[k];
        ry[k+1] <= gy ? ry[k] - dsh : ry[k];
        dv[k+1] <= dv[k];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_res   = st[QB];
endmodule

// ===== hdl/sgi_checker.sv =====
// Checker: port-level properties of the segment intersection unit, with its bind.
`timescale 1ns / 1ps
module sgi_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sgi_pkg::out_t out_data
);
  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // parallel never reports a hit
  a_par: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.parallel |-> !out_data.hit)
    else $error("hit reported on parallel segments");

  // no hit means zero position
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.px == '0 && out_data.py == '0)
    else $error("nonzero position without hit");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // input side is ready whenever output is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind segment_intersection_unit sgi_checker u_sgi_checker (
  .clk(clk), .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== bench/tb_segment_intersection_unit.sv =====
// Testbench for the segment intersection unit: random and directed segment pairs.
`timescale 1ns / 1ps
module tb_segment_intersection_unit;
  import sgi_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  segment_intersection_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  in_t  pending_pairs[$];
  out_t expected_hits[$];
  int   mismatches = 0;
  int   beats_checked = 0;
  int   hits_seen = 0;
  int   parallels_seen = 0;
  bit   stim_done;
  bit   drain_hold;       // sender waits for all results
  bit   stall_req;        // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Append one pair to the stimulus queue
  function automatic void add_pair(in_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // Cross product of two difference vectors
  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic bit within_unit(longint num, longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Predict one intersection beat
  function automatic out_t intersect_pair(in_t p);
    out_t   r;
    longint ax, ay, abx, aby, cdx, cdy, den, sn, tn;
    ax  = p.ax;
    ay  = p.ay;
    abx = longint'(p.bx) - ax;
    aby = longint'(p.by_coord) - ay;
    cdx = longint'(p.dx) - longint'(p.cx);
    cdy = longint'(p.dy) - longint'(p.cy);
    den = cross2(abx, aby, cdx, cdy);
    r = '0;
    if (den == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    sn = cross2(longint'(p.cx) - ax, longint'(p.cy) - ay, cdx, cdy);
    tn = cross2(abx, aby, ax - longint'(p.cx), ay - longint'(p.cy));
    if (!within_unit(sn, den) || !within_unit(tn, den)) return r;
    r.hit = 1'b1;
    r.px  = clamp_coord(ax + (sn * abx) / den);
    r.py  = clamp_coord(ay + (sn * aby) / den);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CW'($signed($urandom_range(0, 15)) - 8);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic in_t make_pair(int xs, int ys, int x0, int y0, int x1, int y1,
                                    int x2, int y2, int x3, int y3);
    in_t p;
    p.ax = CW'(x0 * xs); p.ay = CW'(y0 * ys);
    p.bx = CW'(x1 * xs); p.by_coord = CW'(y1 * ys);
    p.cx = CW'(x2 * xs); p.cy = CW'(y2 * ys);
    p.dx = CW'(x3 * xs); p.dy = CW'(y3 * ys);
    return p;
  endfunction

  // Random pair: mostly crossing segments built around a common point
  function automatic in_t random_pair();
    in_t p;
    int  mode, span, qx, qy;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      span = (mode < 3) ? 255 : 16000;
      qx = $signed($urandom_range(0, 2 * span)) - span;
      qy = $signed($urandom_range(0, 2 * span)) - span;
      p.ax = CW'(qx - $signed($urandom_range(0, span)));
      p.ay = CW'(qy - $signed($urandom_range(0, span)));
      p.bx = CW'(qx + $signed($urandom_range(0, span)));
      p.by_coord = CW'(qy + $signed($urandom_range(0, span)));
      p.cx = CW'(qx + $signed($urandom_range(0, span)));
      p.cy = CW'(qy - $signed($urandom_range(0, span)));
      p.dx = CW'(qx - $signed($urandom_range(0, span)));
      p.dy = CW'(qy + $signed($urandom_range(0, span)));
    end else if (mode == 6) begin
      // parallel: opposite direction vectors
      p.ax = CW'($urandom_range(0, 8000)); p.ay = CW'($urandom_range(0, 8000));
      p.cx = CW'($urandom_range(0, 8000)); p.cy = CW'($urandom_range(0, 8000));
      qx = $urandom_range(0, 4000); qy = $urandom_range(0, 4000);
      p.bx = p.ax + CW'(qx); p.by_coord = p.ay + CW'(qy);
      p.dx = p.cx - CW'(2 * qx); p.dy = p.cy - CW'(2 * qy);
    end else begin
      p.ax = rand_coord(); p.ay = rand_coord(); p.bx = rand_coord();
      p.by_coord = rand_coord(); p.cx = rand_coord(); p.cy = rand_coord();
      p.dx = rand_coord(); p.dy = rand_coord();
    end
    return p;
  endfunction

  // Stimulus: directed corners first, then random pairs
  initial begin
    stim_done = 0; drain_hold = 0; stall_req = 0;
    rst = 1'b1;
    // plain crossing, end-point touch, T junction, parallel, collinear, disjoint
    add_pair(make_pair(256, 256, 0, 0, 4, 4, 0, 4, 4, 0));
    add_pair(make_pair(256, 256, 0, 0, 4, 4, 4, 4, 8, 0));
    add_pair(make_pair(256, 256, 0, 0, 4, 0, 2, 0, 2, 5));
    add_pair(make_pair(256, 256, 0, 0, 4, 0, 0, 1, 4, 1));
    add_pair(make_pair(256, 256, 0, 0, 4, 0, 2, 0, 6, 0));
    add_pair(make_pair(256, 256, 0, 0, 1, 1, 5, 0, 6, -3));
    add_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_pair(make_pair(1, 1, 3, 7, 5, 2, 9, 1, 0, 0));
    // full-scale extremes
    add_pair(make_pair(1, 1, -32768, -32768, 32767, 32767,
                       -32768, 32767, 32767, -32768));
    add_pair(make_pair(1, 1, 32767, -32768, -32768, 32767,
                       32767, 32767, -32768, -32768));
    add_pair(make_pair(1, 1, -32768, 0, 32767, 0, 0, -32768, 0, 32767));
    add_pair(make_pair(1, 1, -32768, -32768, -32768, 32767,
                       -32768, 0, 32767, 0));
    add_pair(make_pair(1, 1, 32767, 32767, 32767, 32767,
                       -32768, -32768, -32768, -32768));
    add_pair(make_pair(1, 1, -1, -1, 1, 1, 1, -1, -1, 1));
    add_pair(make_pair(1, 1, -32768, 32767, 32767, -32767,
                       -32768, -32767, 32767, 32767));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1050; i++) begin
      add_pair(random_pair());
      // long receiver hold-off while the sender keeps going
      if (i == 300) stall_req = 1;
      // sender pause until every result is back
      if (i == 600) begin
        while (pending_pairs.size() != 0) @(posedge clk);
        drain_hold = 1;
        while (expected_hits.size() != 0) @(posedge clk);
        drain_hold = 0;
      end
      if (pending_pairs.size() > 40) @(posedge clk);
    end
    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    stim_done = 1;
  end

  // Driver: bursts of random length with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_hits.insert(expected_hits.size(), intersect_pair(in_data));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() != 0 && !drain_hold) begin
        in_data  <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern plus one long hold-off
  int stall_phase;
  int stall_hold;         // long receiver hold-off, in cycles
  bit stall_taken;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      stall_hold <= 0;
      stall_taken <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      out_ready <= 1'b0;
      stall_hold <= 200;
      stall_taken <= 1'b1;
    end else if (stall_hold > 0) begin
      out_ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 30) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each output beat with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = expected_hits.pop_front();
        beats_checked++;
        if (want.hit) hits_seen++;
        if (want.parallel) parallels_seen++;
        if (out_data.hit !== want.hit || out_data.px !== want.px ||
            out_data.py !== want.py || out_data.parallel !== want.parallel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp hit=%b px=%0d py=%0d par=%b, %s",
                     beats_checked, want.hit, want.px, want.py, want.parallel,
                     $sformatf("got hit=%b px=%0d py=%0d par=%b",
                               out_data.hit, out_data.px, out_data.py,
                               out_data.parallel));
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("checked %0d beats: %0d hits, %0d parallel, %0d disjoint; %0d mismatches",
             beats_checked, hits_seen, parallels_seen,
             beats_checked - hits_seen - parallels_seen, mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
